// ===== rtl/vcr_pkg.sv =====
`default_nettype none

package vcr_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int STEP_BITS      = 31;
    // five times the largest step fits here
    localparam int MULT_BITS      = 34;
    localparam int QUO_BITS       = 8;
    // 255 * remainder, remainder below 2**STEP_BITS
    localparam int NUM_BITS       = STEP_BITS + QUO_BITS;
    localparam int SEGMENTS       = 5;

    localparam logic [7:0] FULL = 8'hff;

    localparam logic REG_LOW_BOUND = 1'b0;
    localparam logic REG_STEP_SIZE = 1'b1;

    typedef enum logic [2:0] {
        SEG_BLUE_UP,
        SEG_GREEN_UP,
        SEG_BLUE_DOWN,
        SEG_RED_UP,
        SEG_GREEN_DOWN
    } vcr_seg_t;

    typedef struct packed {
        logic     black;
        logic     white;
        vcr_seg_t seg;
    } vcr_class_t;

endpackage

`default_nettype wire

// ===== rtl/vcr_front.sv =====
`default_nettype none

// Difference, segment search, remainder and 255 * remainder over four stages.
module vcr_front #(
    parameter int VALUE_BITS = vcr_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 adv,
    input  wire logic                                 in_valid,
    input  wire logic signed [VALUE_BITS-1:0]         sample_value,
    input  wire logic signed [VALUE_BITS-1:0]         low_bound,
    input  wire logic        [vcr_pkg::STEP_BITS-1:0] step_size,
    output logic                                      out_valid,
    output vcr_pkg::vcr_class_t                       out_class,
    output logic             [vcr_pkg::NUM_BITS-1:0]  out_num
);
    import vcr_pkg::*;

    localparam int DW = VALUE_BITS + 1;
    localparam int CW = (DW > MULT_BITS + 1) ? DW : MULT_BITS + 1;

    logic [MULT_BITS-1:0] mult_reg [1:SEGMENTS];

    logic [DW-1:0]        diff_reg;
    logic                 v1_reg;

    logic [CW-1:0]        diff_ext;
    logic [SEGMENTS:1]    ge_reg;
    logic                 black2_reg;
    logic [MULT_BITS-1:0] diff2_reg;
    logic                 v2_reg;

    vcr_class_t           cls3_next;
    vcr_class_t           cls3_reg;
    logic [MULT_BITS-1:0] mult_sel;
    logic [MULT_BITS-1:0] rem_full;
    logic [STEP_BITS-1:0] rem3_reg;
    logic                 v3_reg;

    vcr_class_t           cls4_reg;
    logic [NUM_BITS-1:0]  num4_reg;
    logic                 v4_reg;

    // multiples track step; user must change it only while idle; unenforced
    always_ff @(posedge aclk) begin
        for (int k = 1; k <= SEGMENTS; k++) begin
            mult_reg[k] <= MULT_BITS'(step_size) * MULT_BITS'(k);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign diff_ext = CW'(diff_reg);

    always_comb begin
        cls3_next.black = black2_reg;
        cls3_next.white = ge_reg[5];
        if (ge_reg[4]) begin
            cls3_next.seg = SEG_GREEN_DOWN;
        end else if (ge_reg[3]) begin
            cls3_next.seg = SEG_RED_UP;
        end else if (ge_reg[2]) begin
            cls3_next.seg = SEG_BLUE_DOWN;
        end else if (ge_reg[1]) begin
            cls3_next.seg = SEG_GREEN_UP;
        end else begin
            cls3_next.seg = SEG_BLUE_UP;
        end
    end

    always_comb begin
        unique case (cls3_next.seg)
            SEG_GREEN_UP:   mult_sel = mult_reg[1];
            SEG_BLUE_DOWN:  mult_sel = mult_reg[2];
            SEG_RED_UP:     mult_sel = mult_reg[3];
            SEG_GREEN_DOWN: mult_sel = mult_reg[4];
            default:        mult_sel = '0;
        endcase
    end

    // true remainder is below the step, so low bits suffice
    assign rem_full = diff2_reg - mult_sel;

    always_ff @(posedge aclk) begin
        if (adv) begin
            // one extra sign bit keeps the signed difference exact
            diff_reg <= {sample_value[VALUE_BITS-1], sample_value}
                        - {low_bound[VALUE_BITS-1], low_bound};

            black2_reg <= diff_reg[DW-1];
            diff2_reg  <= diff_ext[MULT_BITS-1:0];
            for (int k = 1; k <= SEGMENTS; k++) begin
                ge_reg[k] <= (diff_ext >= CW'(mult_reg[k]));
            end

            cls3_reg <= cls3_next;
            rem3_reg <= rem_full[STEP_BITS-1:0];

            cls4_reg <= cls3_reg;
            num4_reg <= {rem3_reg, {QUO_BITS{1'b0}}} - NUM_BITS'(rem3_reg);
        end
    end

    assign out_valid = v4_reg;
    assign out_class = cls4_reg;
    assign out_num   = num4_reg;

endmodule

`default_nettype wire

// ===== rtl/vcr_div.sv =====
`default_nettype none

// Restoring divide of 255 * remainder by the step, one quotient bit a stage.
module vcr_div (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 adv,
    input  wire logic                                 in_valid,
    input  wire vcr_pkg::vcr_class_t                  in_class,
    input  wire logic        [vcr_pkg::NUM_BITS-1:0]  in_num,
    input  wire logic        [vcr_pkg::STEP_BITS-1:0] step_size,
    output logic                                      out_valid,
    output vcr_pkg::vcr_class_t                       out_class,
    output logic             [vcr_pkg::QUO_BITS-1:0]  out_ramp
);
    import vcr_pkg::*;

    logic                vld_reg  [1:QUO_BITS];
    vcr_class_t          cls_reg  [1:QUO_BITS];
    logic [NUM_BITS-1:0] part_reg [1:QUO_BITS];
    logic [QUO_BITS-1:0] quo_reg  [1:QUO_BITS];

    logic                vld_in   [0:QUO_BITS-1];
    vcr_class_t          cls_in   [0:QUO_BITS-1];
    logic [NUM_BITS-1:0] part_in  [0:QUO_BITS-1];
    logic [QUO_BITS-1:0] quo_in   [0:QUO_BITS-1];

    assign vld_in[0]  = in_valid;
    assign cls_in[0]  = in_class;
    assign part_in[0] = in_num;
    assign quo_in[0]  = '0;

    for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
        logic [NUM_BITS-1:0] dsh;
        logic [NUM_BITS:0]   trial;

        assign dsh   = NUM_BITS'(step_size) << (QUO_BITS - 1 - i);
        assign trial = {1'b0, part_in[i]} - {1'b0, dsh};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[i+1] <= vld_in[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                cls_reg[i+1]  <= cls_in[i];
                part_reg[i+1] <= trial[NUM_BITS] ? part_in[i] : trial[NUM_BITS-1:0];
                quo_reg[i+1]  <= {quo_in[i][QUO_BITS-2:0], ~trial[NUM_BITS]};
            end
        end

        if (i > 0) begin : g_link
            assign vld_in[i]  = vld_reg[i];
            assign cls_in[i]  = cls_reg[i];
            assign part_in[i] = part_reg[i];
            assign quo_in[i]  = quo_reg[i];
        end
    end

    assign out_valid = vld_reg[QUO_BITS];
    assign out_class = cls_reg[QUO_BITS];
    assign out_ramp  = quo_reg[QUO_BITS];

endmodule

`default_nettype wire

// ===== rtl/value_to_colour_ramp.sv =====
`default_nettype none

// Maps a signed sample to an RGB colour on a five-segment rainbow scale
// (blue, cyan, green, yellow, red), black below low_bound and white from
// low_bound + 5 * step_size up. One transfer is taken every cycle unless the
// pipeline holds; each result passes the front end, the eight-stage divider
// that forms the ramp 255 * (diff mod step) / step, and the output register.
// The whole pipeline holds while m_tready is low and a result waits.
// Registers are written through cfg_*: index 0 is low_bound, index 1 is
// step_size (low 31 bits of cfg_data). Write them only with the pipeline empty.
module value_to_colour_ramp #(
    parameter int VALUE_BITS = vcr_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    // sample_value
    input  wire logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    // blue, green, red from the top byte down
    output logic [23:0]                                  m_tdata,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic                                    cfg_index,
    input  wire logic [((VALUE_BITS > vcr_pkg::STEP_BITS) ?
                        VALUE_BITS : vcr_pkg::STEP_BITS) - 1:0] cfg_data
);
    import vcr_pkg::*;

    logic signed [VALUE_BITS-1:0] low_bound_reg;
    logic        [STEP_BITS-1:0]  step_size_reg;

    logic                adv;
    logic                f_valid;
    vcr_class_t          f_class;
    logic [NUM_BITS-1:0] f_num;
    logic                d_valid;
    vcr_class_t          d_class;
    logic [QUO_BITS-1:0] d_ramp;

    logic [7:0] red_next, green_next, blue_next;
    logic [7:0] red_reg, green_reg, blue_reg;
    logic       out_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_bound_reg <= '0;
            step_size_reg <= STEP_BITS'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LOW_BOUND: low_bound_reg <= cfg_data[VALUE_BITS-1:0];
                REG_STEP_SIZE: step_size_reg <= cfg_data[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    vcr_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (s_tvalid),
        .sample_value (s_tdata[VALUE_BITS-1:0]),
        .low_bound    (low_bound_reg),
        .step_size    (step_size_reg),
        .out_valid    (f_valid),
        .out_class    (f_class),
        .out_num      (f_num)
    );

    vcr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_class  (f_class),
        .in_num    (f_num),
        .step_size (step_size_reg),
        .out_valid (d_valid),
        .out_class (d_class),
        .out_ramp  (d_ramp)
    );

    always_comb begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        if (d_class.black) begin
            red_next   = '0;
        end else if (d_class.white) begin
            red_next   = FULL;
            green_next = FULL;
            blue_next  = FULL;
        end else begin
            case (d_class.seg)
                SEG_BLUE_UP: begin
                    blue_next = d_ramp;
                end
                SEG_GREEN_UP: begin
                    green_next = d_ramp;
                    blue_next  = FULL;
                end
                SEG_BLUE_DOWN: begin
                    green_next = FULL;
                    blue_next  = FULL - d_ramp;
                end
                SEG_RED_UP: begin
                    red_next   = d_ramp;
                    green_next = FULL;
                end
                default: begin
                    red_next   = FULL;
                    green_next = FULL - d_ramp;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};

endmodule

`default_nettype wire
